### hdl/tcgp_pkg.sv
package tcgp_pkg;

  localparam int unsigned PANEL_SHORT = 128;
  localparam int unsigned PANEL_LONG  = 296;
  localparam int unsigned GLYPH_ROWS  = 8;
  localparam int unsigned GLYPH_COLS  = 8;

  localparam int unsigned GLYPH_COUNT = 224;
  localparam int unsigned LINE_BYTES  = (PANEL_SHORT + 7) / 8;
  localparam int unsigned FRAME_BYTES = LINE_BYTES * PANEL_LONG;
  localparam int unsigned GLYPH_BYTES = GLYPH_COUNT * GLYPH_ROWS;

  localparam logic [7:0] FIRST_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] WHITE_BYTE   = 8'hFF;

  typedef enum logic [1:0] {
    MODE_PRINT = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  // cursor step request from the sequencer
  typedef struct packed {
    logic step;
    logic newline;
  } cur_cmd_t;

  // cursor position and wrap indication for the pending step
  typedef struct packed {
    logic [8:0] along;
    logic [6:0] across;
    logic       wrap;
  } cur_stat_t;

endpackage

### hdl/text_cursor_glyph_plotter.sv
// print: the 8 glyph rows are each read then written on the frame port, then the cursor steps
// newline/control code: cursor step only; read: S_READ then S_RCAP; clear: all bytes to white
// a wrap past the bottom adds the frame sweep to white to a print
// requests do not overlap; in_stall_o is high while a request is at work
// after reset the frame store is swept to white with in_stall_o high
// cursor and line_gap reset to zero, the glyph store is not initialized
module text_cursor_glyph_plotter
  import tcgp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  glyph_slot_i,
  input  logic [2:0]  glyph_row_i,
  input  logic [7:0]  row_bits_i,
  input  logic [12:0] frame_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [8:0]  cursor_along_o,
  output logic [6:0]  cursor_across_o,
  output logic        screen_wrapped_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRD   = 3'd1;
  localparam logic [2:0] S_PWR   = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_RCAP  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [2:0]  LastRow  = 3'(GLYPH_ROWS - 1);
  localparam logic [12:0] LastByte = 13'(FRAME_BYTES - 1);

  logic [2:0]  state_q, state_d;
  logic [2:0]  row_q, row_d;
  logic [12:0] clr_cnt_q, clr_cnt_d;
  logic        pend_q, pend_d;
  logic        wrapped_q, wrapped_d;
  logic [7:0]  rdata_q, rdata_d;
  logic [7:0]  code_q;
  logic [7:0]  slot_q;
  logic [12:0] addr_q;
  logic        addr_ok_q;

  logic        out_valid_q;
  logic [7:0]  out_data_q;
  logic [8:0]  out_along_q;
  logic [6:0]  out_across_q;
  logic        out_wrap_q;

  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [7:0]  glyph_mem [GLYPH_BYTES];
  logic [7:0]  fr_rdata_q;
  logic [7:0]  gl_rdata_q;
  logic [12:0] fr_raddr;
  logic [12:0] fr_waddr;
  logic [7:0]  fr_wdata;
  logic        fr_we;
  logic        gl_we;
  logic [10:0] gl_waddr;
  logic [10:0] gl_raddr;

  logic [8:0]  plot_along;
  logic [12:0] plot_addr;
  logic        accept;
  logic        out_free;

  cur_cmd_t    cur_cmd;
  cur_stat_t   cur_stat;

  tcgp_cursor u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cur_cmd),
    .stat_o      (cur_stat)
  );

  function automatic logic [7:0] bit_rev(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // the cursor across position is always a multiple of the glyph width, so a
  // glyph row lands in one frame byte: byte (15 - across/8) of its line, bits reversed
  assign plot_along = cur_stat.along + {6'd0, row_q};
  assign plot_addr  = {plot_along, ~cur_stat.across[6:3]};
  assign gl_raddr   = {slot_q, row_q};
  assign gl_waddr   = {glyph_slot_i, glyph_row_i};

  always_comb begin
    fr_raddr = (state_q == S_READ) ? addr_q : plot_addr;
    fr_we    = 1'b0;
    fr_waddr = plot_addr;
    fr_wdata = fr_rdata_q & ~bit_rev(gl_rdata_q);
    if (state_q == S_PWR) begin
      fr_we = 1'b1;
    end else if (state_q == S_CLEAR) begin
      fr_we    = 1'b1;
      fr_waddr = clr_cnt_q;
      fr_wdata = WHITE_BYTE;
    end
    gl_we = accept && (mode_e'(mode_i) == MODE_LOAD) && (glyph_slot_i < 8'(GLYPH_COUNT))
            && (glyph_row_i <= LastRow);
  end

  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      frame_mem[fr_waddr] <= fr_wdata;
    end
    fr_rdata_q <= frame_mem[fr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (gl_we) begin
      glyph_mem[gl_waddr] <= row_bits_i;
    end
    gl_rdata_q <= glyph_mem[gl_raddr];
  end

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    clr_cnt_d   = clr_cnt_q;
    pend_d      = pend_q;
    wrapped_d   = wrapped_q;
    rdata_d     = rdata_q;
    cur_cmd     = '0;
    in_stall_o  = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pend_d    = 1'b1;
          wrapped_d = 1'b0;
          rdata_d   = '0;
          row_d     = '0;
          clr_cnt_d = '0;
          unique case (mode_e'(mode_i))
            MODE_PRINT: begin
              if (char_code_i == NEWLINE_CODE || char_code_i < FIRST_CODE) begin
                state_d = S_STEP;
              end else begin
                state_d = S_PRD;
              end
            end
            MODE_LOAD:  state_d = S_DONE;
            MODE_READ:  state_d = S_READ;
            MODE_CLEAR: state_d = S_CLEAR;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_PRD: state_d = S_PWR;
      S_PWR: begin
        row_d   = row_q + 3'd1;
        state_d = (row_q == LastRow) ? S_STEP : S_PRD;
      end
      S_STEP: begin
        cur_cmd.step    = 1'b1;
        cur_cmd.newline = (code_q == NEWLINE_CODE);
        wrapped_d       = cur_stat.wrap;
        clr_cnt_d       = '0;
        state_d         = cur_stat.wrap ? S_CLEAR : S_DONE;
      end
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 13'd1;
        if (clr_cnt_q == LastByte) begin
          state_d = pend_q ? S_DONE : S_IDLE;
        end
      end
      S_READ: state_d = S_RCAP;
      S_RCAP: begin
        rdata_d = addr_ok_q ? fr_rdata_q : '0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          pend_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      row_q       <= '0;
      clr_cnt_q   <= '0;
      pend_q      <= 1'b0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      clr_cnt_q <= clr_cnt_d;
      pend_q    <= pend_d;
      wrapped_q <= wrapped_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    if (accept) begin
      code_q    <= char_code_i;
      slot_q    <= char_code_i - FIRST_CODE;
      addr_q    <= frame_address_i;
      addr_ok_q <= (frame_address_i <= LastByte);
    end
    if (state_q == S_DONE && out_free) begin
      out_data_q   <= rdata_q;
      out_along_q  <= cur_stat.along;
      out_across_q <= cur_stat.across;
      out_wrap_q   <= wrapped_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_data_q;
  assign cursor_along_o   = out_along_q;
  assign cursor_across_o  = out_across_q;
  assign screen_wrapped_o = out_wrap_q;

  a_pwr_same_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PWR) |-> (fr_waddr == $past(fr_raddr)))
    else $error("plot write address differs from its read address");

  a_result_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pend_q))
    else $error("result produced without a pending request");

  a_clear_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (clr_cnt_q <= LastByte))
    else $error("clear sweep ran past the frame store");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE) && pend_q)
    else $error("accepted request not taken up");

  a_wrap_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP && cur_stat.wrap) |=> (state_q == S_CLEAR) && (clr_cnt_q == '0))
    else $error("wrap did not start a frame sweep");

endmodule

### hdl/tcgp_cursor.sv
module tcgp_cursor
  import tcgp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  cur_cmd_t   cmd_i,
  output cur_stat_t  stat_o
);

  localparam logic [7:0] AcrossLimit = 8'(PANEL_SHORT - GLYPH_COLS);
  localparam logic [9:0] AlongLimit  = 10'(PANEL_LONG - GLYPH_ROWS);

  logic [3:0] line_gap_q;
  logic [8:0] along_q, along_d;
  logic [6:0] across_q, across_d;
  logic [7:0] across_sum;
  logic [9:0] line_sum;
  logic       line_feed;
  logic       wrap;

  always_comb begin
    across_sum = {1'b0, across_q} + 8'(GLYPH_COLS);
    line_sum   = {1'b0, along_q} + 10'(GLYPH_ROWS) + {6'd0, line_gap_q};
    // next line when asked, or when no room is left for another glyph
    line_feed  = cmd_i.newline || (across_sum > AcrossLimit);
    wrap       = line_feed && (line_sum > AlongLimit);
    along_d    = along_q;
    across_d   = across_q;
    if (cmd_i.step) begin
      if (line_feed) begin
        across_d = '0;
        along_d  = wrap ? '0 : line_sum[8:0];
      end else begin
        across_d = across_sum[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_gap_q <= '0;
      along_q    <= '0;
      across_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        line_gap_q <= cfg_wdata_i;
      end
      along_q  <= along_d;
      across_q <= across_d;
    end
  end

  assign stat_o.along  = along_q;
  assign stat_o.across = across_q;
  assign stat_o.wrap   = cmd_i.step && wrap;

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcgp_pkg::*;

  // worst case is dominated by the frame sweeps (reset, clears, wraps),
  // roughly fifty of them, plus ~600 requests stretched by random stalls
  localparam int unsigned LIMIT_CYCLES  = 1_500_000;
  localparam int unsigned RANDOM_ITEMS  = 550;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned DRAIN_CYCLES  = 40;

  localparam logic [7:0] DIRECTED_ART [8] = '{
    8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h00, 8'h3C, 8'hC3
  };
  localparam logic [3:0] GAP_PLAN [RANDOM_PHASES] = '{4'd15, 4'd0, 4'd6, 4'd1, 4'd15};

  typedef struct {
    mode_e       mode;
    logic [7:0]  char_code;
    logic [7:0]  glyph_slot;
    logic [2:0]  glyph_row;
    logic [7:0]  row_bits;
    logic [12:0] frame_address;
  } plot_req_t;

  typedef struct {
    logic [7:0] read_data;
    logic [8:0] along;
    logic [6:0] across;
    logic       wrapped;
  } plot_res_t;

  class glyph_plot_scoreboard;
    logic [7:0]  frame_bytes [FRAME_BYTES];
    logic [7:0]  glyph_bytes [GLYPH_BYTES];
    int unsigned line_pos;
    int unsigned column_pos;
    int unsigned line_gap;
    int unsigned errors;
    plot_res_t   expected_reports [$];

    function new();
      foreach (glyph_bytes[i]) glyph_bytes[i] = 8'h00;
      whiten();
      line_pos   = 0;
      column_pos = 0;
      line_gap   = 0;
      errors     = 0;
    endfunction

    function void whiten();
      foreach (frame_bytes[i]) frame_bytes[i] = WHITE_BYTE;
    endfunction

    // returns 1 when the move runs past the bottom and clears the frame
    function bit next_line();
      line_pos += GLYPH_ROWS + line_gap;
      column_pos = 0;
      if (line_pos + GLYPH_ROWS > PANEL_LONG) begin
        line_pos = 0;
        whiten();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void plot(logic [7:0] code);
      int unsigned slot;
      int unsigned along;
      int unsigned acr_off;
      int unsigned across;
      int unsigned pos;
      logic [7:0]  pattern;
      if (line_pos >= PANEL_LONG || column_pos >= PANEL_SHORT || code < FIRST_CODE) return;
      slot = 32'(code - FIRST_CODE);
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        pattern = glyph_bytes[slot * GLYPH_ROWS + r];
        along = line_pos + r;
        if (along < PANEL_LONG) begin
          for (int k = 0; k < GLYPH_COLS; k++) begin
            acr_off = column_pos + k;
            if (pattern[7 - k] && acr_off < PANEL_SHORT) begin
              // glyph columns run down the short edge, mirrored
              across = PANEL_SHORT - 1 - acr_off;
              pos = along * LINE_BYTES + across / 8;
              if (pos < FRAME_BYTES) frame_bytes[pos] &= ~(8'h80 >> (across % 8));
            end
          end
        end
      end
    endfunction

    function void note_request(plot_req_t q);
      plot_res_t res;
      res.read_data = 8'h00;
      res.wrapped   = 1'b0;
      case (q.mode)
        MODE_PRINT: begin
          if (q.char_code == NEWLINE_CODE) begin
            res.wrapped = next_line();
          end else begin
            plot(q.char_code);
            column_pos += GLYPH_COLS;
            if (column_pos + GLYPH_COLS > PANEL_SHORT) res.wrapped = next_line();
          end
        end
        MODE_LOAD: begin
          if (q.glyph_slot < GLYPH_COUNT && q.glyph_row < GLYPH_ROWS)
            glyph_bytes[q.glyph_slot * GLYPH_ROWS + q.glyph_row] = q.row_bits;
        end
        MODE_READ: begin
          if (q.frame_address < FRAME_BYTES) res.read_data = frame_bytes[q.frame_address];
        end
        default: begin
          whiten();
        end
      endcase
      res.along  = 9'(line_pos);
      res.across = 7'(column_pos);
      expected_reports.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(plot_res_t got);
      plot_res_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch("result with no request waiting");
        return;
      end
      want = expected_reports.pop_front();
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("read_data got %h want %h", got.read_data, want.read_data));
      if (got.along !== want.along)
        report_mismatch($sformatf("cursor_along got %0d want %0d", got.along, want.along));
      if (got.across !== want.across)
        report_mismatch($sformatf("cursor_across got %0d want %0d", got.across, want.across));
      if (got.wrapped !== want.wrapped)
        report_mismatch($sformatf("screen_wrapped got %b want %b", got.wrapped, want.wrapped));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [7:0]  char_code_i;
  logic [7:0]  glyph_slot_i;
  logic [2:0]  glyph_row_i;
  logic [7:0]  row_bits_i;
  logic [12:0] frame_address_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  read_data_o;
  logic [8:0]  cursor_along_o;
  logic [6:0]  cursor_across_o;
  logic        screen_wrapped_o;

  glyph_plot_scoreboard sb;
  logic [7:0]  rows_loaded [GLYPH_COUNT];
  logic [7:0]  ready_codes [$];
  bit          no_idle;
  int unsigned cycle_count;

  text_cursor_glyph_plotter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .char_code_i      (char_code_i),
    .glyph_slot_i     (glyph_slot_i),
    .glyph_row_i      (glyph_row_i),
    .row_bits_i       (row_bits_i),
    .frame_address_i  (frame_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_data_o      (read_data_o),
    .cursor_along_o   (cursor_along_o),
    .cursor_across_o  (cursor_across_o),
    .screen_wrapped_o (screen_wrapped_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = !no_idle && ($urandom_range(0, 99) < 26);
  end

  always @(posedge clk_i) begin : watch_results
    plot_res_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.read_data = read_data_o;
      seen.along     = cursor_along_o;
      seen.across    = cursor_across_o;
      seen.wrapped   = screen_wrapped_o;
      sb.check_result(seen);
    end
  end

  function automatic plot_req_t random_request(mode_e m);
    plot_req_t q;
    q.mode          = m;
    q.char_code     = 8'($urandom_range(0, 255));
    q.glyph_slot    = 8'($urandom_range(0, 255));
    q.glyph_row     = 3'($urandom_range(0, 7));
    q.row_bits      = 8'($urandom_range(0, 255));
    q.frame_address = 13'($urandom_range(0, 8191));
    return q;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(plot_req_t q);
    while (!no_idle && $urandom_range(0, 99) < 26) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    mode_i          = q.mode;
    char_code_i     = q.char_code;
    glyph_slot_i    = q.glyph_slot;
    glyph_row_i     = q.glyph_row;
    row_bits_i      = q.row_bits;
    frame_address_i = q.frame_address;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(q);
    // only fully loaded glyphs may be printed
    if (q.mode == MODE_LOAD && q.glyph_slot < GLYPH_COUNT && rows_loaded[q.glyph_slot] != 8'hFF) begin
      rows_loaded[q.glyph_slot][q.glyph_row] = 1'b1;
      if (rows_loaded[q.glyph_slot] == 8'hFF) ready_codes.push_back(q.glyph_slot + FIRST_CODE);
    end
    @(negedge clk_i);
  endtask

  task automatic send_print(logic [7:0] code);
    plot_req_t q;
    q = random_request(MODE_PRINT);
    q.char_code = code;
    send_request(q);
  endtask

  task automatic send_load(logic [7:0] slot, logic [2:0] row, logic [7:0] bits);
    plot_req_t q;
    q = random_request(MODE_LOAD);
    q.glyph_slot = slot;
    q.glyph_row  = row;
    q.row_bits   = bits;
    send_request(q);
  endtask

  task automatic send_read(logic [12:0] addr);
    plot_req_t q;
    q = random_request(MODE_READ);
    q.frame_address = addr;
    send_request(q);
  endtask

  task automatic send_clear();
    send_request(random_request(MODE_CLEAR));
  endtask

  task automatic pause_for_idle();
    in_valid_i = 1'b0;
    while (sb.expected_reports.size() != 0 || in_stall_o) @(negedge clk_i);
  endtask

  task automatic write_line_gap(logic [3:0] gap);
    pause_for_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = gap;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.line_gap = 32'(gap);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned along;
    logic [7:0]  slot;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        slot = 8'($urandom_range(0, GLYPH_COUNT - 1));
        for (int r = 0; r < GLYPH_ROWS; r++)
          send_load(slot, 3'(r), 8'($urandom_range(0, 255)));
        sent += GLYPH_ROWS;
      end else if (pick < 16) begin
        // stray load, may hit a slot past the glyph table
        send_load(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)));
        sent++;
      end else if (pick < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 12)
          send_print(NEWLINE_CODE);
        else if (pick < 22 || ready_codes.size() == 0)
          send_print(8'($urandom_range(0, FIRST_CODE - 1)));
        else
          send_print(ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
        sent++;
      end else if (pick < 98) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          send_read(13'($urandom_range(FRAME_BYTES, 8191)));
        end else if (pick < 35) begin
          send_read(13'($urandom_range(0, FRAME_BYTES - 1)));
        end else begin
          // around the cursor and the line just above, where the ink is
          along = (sb.line_pos + PANEL_LONG - 24 + $urandom_range(0, 31)) % PANEL_LONG;
          send_read(13'(along * LINE_BYTES + $urandom_range(0, LINE_BYTES - 1)));
        end
        sent++;
      end else begin
        send_clear();
        sent++;
      end
    end
  endtask

  initial begin
    sb              = new();
    foreach (rows_loaded[i]) rows_loaded[i] = 8'h00;
    no_idle         = 1'b0;
    cycle_count     = 0;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 4'd0;
    in_valid_i      = 1'b0;
    out_stall_i     = 1'b0;
    mode_i          = MODE_PRINT;
    char_code_i     = 8'h00;
    glyph_slot_i    = 8'h00;
    glyph_row_i     = 3'd0;
    row_bits_i      = 8'h00;
    frame_address_i = 13'd0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset frame, address edges, one glyph drawn and read back
    send_read(13'd0);
    send_read(13'(FRAME_BYTES - 1));
    send_read(13'(FRAME_BYTES));
    send_read(13'h1FFF);
    for (int r = 0; r < GLYPH_ROWS; r++)
      send_load(8'(GLYPH_COUNT - 1), 3'(r), DIRECTED_ART[r]);
    send_load(8'(GLYPH_COUNT), 3'd0, 8'hFF);
    send_load(8'hFF, 3'd7, 8'hFF);
    send_print(8'hFF);
    send_read(13'(LINE_BYTES - 1));
    send_read(13'(2 * LINE_BYTES - 1));
    send_print(8'h00);
    send_print(8'(FIRST_CODE - 1));
    send_print(NEWLINE_CODE);
    send_clear();
    send_read(13'(LINE_BYTES - 1));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_line_gap(GAP_PLAN[p]);
      no_idle = (p == 2);
      run_random(RANDOM_ITEMS / RANDOM_PHASES);
    end
    no_idle = 1'b0;

    pause_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_reports.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_reports.size()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
